[src/vau_pkg.sv]
// Shared types, operation and status codes, and pipeline depth helpers
// for the three-component vector arithmetic unit. No dependencies.
package vau_pkg;

    localparam int VAU_DATA_WIDTH = 32;
    localparam int VAU_FRAC_BITS  = 16;
    localparam int OP_W           = 3;
    localparam int ERR_W          = 2;

    // operation codes carried in s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_DIV   = 3'd3,
        OP_NORM  = 3'd4,
        OP_LIMIT = 3'd5
    } op_t;

    // status codes carried in m_tuser
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_ZERO_VEC = 2'd2
    } err_t;

    // per-item control handed from the decision stage to each lane
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            s_zero;   // scalar is zero
        logic            m_zero;   // vector magnitude is zero
        logic            go;       // limit operation rescales
    } lane_flags_t;

    // magnitude unit: squares, sum, one root bit per stage
    function automatic int mag_depth(input int dw);
        return dw + 2;
    endfunction

    // lane: one quotient bit per stage, round, multiply, scale/select
    function automatic int lane_depth(input int dw, input int fb);
        return dw + fb + 3;
    endfunction

endpackage

[src/vau_mag.sv]
// Euclidean magnitude: squares of three component magnitudes, their sum,
// and a pipelined digit-by-digit integer square root. Uses vau_pkg.
module vau_mag
    import vau_pkg::*;
#(
    parameter int DATA_WIDTH = VAU_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [DATA_WIDTH-1:0] ax_mag,
    input  logic [DATA_WIDTH-1:0] ay_mag,
    input  logic [DATA_WIDTH-1:0] az_mag,
    output logic [DATA_WIDTH-1:0] mag
);
    localparam int W  = DATA_WIDTH;
    localparam int SW = 2 * W;
    localparam int RW = W + 2;

    logic [SW-1:0] sq_reg [3];
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] rad_reg  [W];
    logic [RW-1:0] rem_reg  [W];
    logic [W-1:0]  root_reg [W];

    // squares, then their sum (fits 2W bits: at most three quarters of 2^2W)
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg[0] <= SW'(ax_mag) * SW'(ax_mag);
            sq_reg[1] <= SW'(ay_mag) * SW'(ay_mag);
            sq_reg[2] <= SW'(az_mag) * SW'(az_mag);
            sum_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // one root bit per stage, most significant first
    for (genvar k = 0; k < W; k++) begin : g_root
        logic [SW-1:0] rad_in;
        logic [RW-1:0] rem_in;
        logic [W-1:0]  root_in;
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;
        logic          take;

        if (k == 0) begin : g_first
            assign rad_in  = sum_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign cur   = {rem_in[RW-3:0], rad_in[SW-1:SW-2]};
        assign trial = {root_in, 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= {rad_in[SW-3:0], 2'b00};
                rem_reg[k]  <= take ? (cur - trial) : cur;
                root_reg[k] <= {root_in[W-2:0], take};
            end
        end
    end

    assign mag = root_reg[W-1];

endmodule

[src/vau_lane.sv]
// One component lane: restoring divider (one quotient bit per stage),
// rounding, product with the scalar, saturation and result selection.
// Uses vau_pkg.
module vau_lane
    import vau_pkg::*;
#(
    parameter int DATA_WIDTH = VAU_DATA_WIDTH,
    parameter int FRAC_BITS  = VAU_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  en,
    input  lane_flags_t           flags,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    input  logic [DATA_WIDTH-1:0] s,
    input  logic [DATA_WIDTH-1:0] dvs,    // divisor magnitude
    input  logic                  qneg,   // quotient sign
    output logic [DATA_WIDTH-1:0] r
);
    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int QW   = W + F;
    localparam int SATW = (QW + 1 > 2 * W + 1) ? QW + 1 : 2 * W + 1;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // clamp a magnitude to the signed range and apply the sign
    function automatic logic [W-1:0] sat(input logic neg, input logic [SATW-1:0] m);
        logic [SATW-1:0] lim;
        logic [W-1:0]    mm;
        lim = neg ? SATW'(MINV) : SATW'(MAXV);
        mm  = (m > lim) ? lim[W-1:0] : m[W-1:0];
        return neg ? (~mm + 1'b1) : mm;
    endfunction

    // clamp a W+1 bit signed sum
    function automatic logic [W-1:0] clamp(input logic [W:0] v);
        if (v[W] != v[W-1]) begin
            return v[W] ? MINV : MAXV;
        end
        return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] absw(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // divider stages
    logic [W-1:0]  rem_reg [QW];
    logic [QW-1:0] num_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [W-1:0]  d_reg   [QW];
    lane_flags_t   flg_reg [QW];
    logic [W-1:0]  a_reg   [QW];
    logic [W-1:0]  b_reg   [QW];
    logic [W-1:0]  s_reg   [QW];
    logic          qn_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [W-1:0]  rem_in;
        logic [QW-1:0] num_in;
        logic [QW-1:0] quo_in;
        logic [W-1:0]  d_in;
        lane_flags_t   flg_in;
        logic [W-1:0]  a_in;
        logic [W-1:0]  b_in;
        logic [W-1:0]  s_in;
        logic          qn_in;
        logic [W:0]    cur;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = {absw(a), {F{1'b0}}};
            assign quo_in = '0;
            assign d_in   = dvs;
            assign flg_in = flags;
            assign a_in   = a;
            assign b_in   = b;
            assign s_in   = s;
            assign qn_in  = qneg;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign flg_in = flg_reg[k-1];
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign s_in   = s_reg[k-1];
            assign qn_in  = qn_reg[k-1];
        end

        assign cur  = {rem_in, num_in[QW-1]};
        assign take = (cur >= {1'b0, d_in});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? W'(cur - {1'b0, d_in}) : cur[W-1:0];
                num_reg[k] <= {num_in[QW-2:0], 1'b0};
                quo_reg[k] <= {quo_in[QW-2:0], take};
                d_reg[k]   <= d_in;
                flg_reg[k] <= flg_in;
                a_reg[k]   <= a_in;
                b_reg[k]   <= b_in;
                s_reg[k]   <= s_in;
                qn_reg[k]  <= qn_in;
            end
        end
    end

    // round half away from zero, saturate the quotient
    lane_flags_t  rs_flg_reg;
    logic [W-1:0] rs_a_reg, rs_b_reg, rs_s_reg, rs_nq_reg;
    logic         round_up;
    logic [QW:0]  q_round;

    assign round_up = ({rem_reg[QW-1], 1'b0} >= {1'b0, d_reg[QW-1]});
    assign q_round  = {1'b0, quo_reg[QW-1]} + (QW+1)'(round_up);

    always_ff @(posedge aclk) begin
        if (en) begin
            rs_flg_reg <= flg_reg[QW-1];
            rs_a_reg   <= a_reg[QW-1];
            rs_b_reg   <= b_reg[QW-1];
            rs_s_reg   <= s_reg[QW-1];
            rs_nq_reg  <= sat(qn_reg[QW-1], SATW'(q_round));
        end
    end

    // magnitude product with the scalar
    lane_flags_t    ms_flg_reg;
    logic [W-1:0]   ms_a_reg, ms_b_reg, ms_nq_reg;
    logic [2*W-1:0] ms_prod_reg;
    logic           ms_pneg_reg;
    logic [W-1:0]   mul_x;

    assign mul_x = (rs_flg_reg.op == OP_SCALE) ? rs_a_reg : rs_nq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ms_flg_reg  <= rs_flg_reg;
            ms_a_reg    <= rs_a_reg;
            ms_b_reg    <= rs_b_reg;
            ms_nq_reg   <= rs_nq_reg;
            ms_prod_reg <= (2*W)'(absw(mul_x)) * (2*W)'(absw(rs_s_reg));
            ms_pneg_reg <= mul_x[W-1] ^ rs_s_reg[W-1];
        end
    end

    // scale back by the fraction bits and pick the result
    logic [SATW-1:0] scaled_mag;
    logic [W-1:0]    scaled;
    logic [W-1:0]    dz_val;
    logic [W-1:0]    r_next;
    logic [W-1:0]    r_reg;

    assign scaled_mag = (SATW'(ms_prod_reg) + (SATW'(1) << (F - 1))) >> F;
    assign scaled     = sat(ms_pneg_reg, scaled_mag);
    assign dz_val     = (ms_a_reg == '0) ? '0 : (ms_a_reg[W-1] ? MINV : MAXV);

    always_comb begin
        case (ms_flg_reg.op)
            OP_ADD:   r_next = clamp({ms_a_reg[W-1], ms_a_reg} + {ms_b_reg[W-1], ms_b_reg});
            OP_SUB:   r_next = clamp({ms_a_reg[W-1], ms_a_reg} - {ms_b_reg[W-1], ms_b_reg});
            OP_SCALE: r_next = scaled;
            OP_DIV:   r_next = ms_flg_reg.s_zero ? dz_val : ms_nq_reg;
            OP_NORM:  r_next = ms_flg_reg.m_zero ? '0 : ms_nq_reg;
            OP_LIMIT: begin
                if (ms_flg_reg.go) begin
                    r_next = ms_flg_reg.m_zero ? '0 : scaled;
                end else begin
                    r_next = ms_a_reg;
                end
            end
            default:  r_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

[src/vector3_arith_unit_top.sv]
// Top level of the three-component vector arithmetic unit: input stage,
// magnitude unit, decision stage, three component lanes, output skid.
// Uses vau_pkg, vau_mag and vau_lane.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata ax..scalar, tuser op code
//  m_       | out       | m_tvalid/m_tready  | tdata rx,ry,rz, tuser status
//
// One transaction per cycle sustained while the skid register is empty. The
// pipeline depth is set by the square-root stage chain in vau_mag and
// the restoring divider chain in each lane.
// aresetn is synchronous, active low; it clears the valid line, output valid and skid.
// A stall on m_tready freezes the pipeline once the skid register holds an
// item; until then transactions are still accepted.
module vector3_arith_unit_top
    import vau_pkg::*;
#(
    parameter int DATA_WIDTH = VAU_DATA_WIDTH,
    parameter int FRAC_BITS  = VAU_FRAC_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // ax, ay, az, bx, by_comp, bz, scalar from bit 0 up, zero padded
    input  logic [((7*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
    // operation
    input  logic [OP_W-1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // rx, ry, rz from bit 0 up, zero padded
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
    // error_code, was_limited from bit 0 up
    output logic [ERR_W:0]                         m_tuser
);
    localparam int W   = DATA_WIDTH;
    localparam int MD  = mag_depth(DATA_WIDTH);
    localparam int LD  = lane_depth(DATA_WIDTH, FRAC_BITS);
    localparam int VD  = MD + LD + 2;
    localparam int MDW = ((3*DATA_WIDTH+7)/8)*8;

    function automatic logic [W-1:0] absw(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic en;
    logic accept;
    logic skid_vld_reg;

    assign en       = ~skid_vld_reg;
    assign s_tready = en;
    assign accept   = s_tvalid & s_tready;

    // valid line, one bit per pipeline register rank
    logic [VD-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[VD-2:0], accept};
        end
    end

    // input register
    logic [OP_W-1:0] in_op_reg;
    logic [W-1:0]    in_a_reg [3];
    logic [W-1:0]    in_b_reg [3];
    logic [W-1:0]    in_s_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            in_op_reg <= s_tuser;
            for (int i = 0; i < 3; i++) begin
                in_a_reg[i] <= s_tdata[i*W +: W];
                in_b_reg[i] <= s_tdata[(i+3)*W +: W];
            end
            in_s_reg <= s_tdata[6*W +: W];
        end
    end

    // magnitude of the first vector
    logic [W-1:0] mag;

    vau_mag #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mag (
        .aclk   (aclk),
        .en     (en),
        .ax_mag (absw(in_a_reg[0])),
        .ay_mag (absw(in_a_reg[1])),
        .az_mag (absw(in_a_reg[2])),
        .mag    (mag)
    );

    // item fields delayed alongside the magnitude unit
    logic [OP_W-1:0] dly_op_reg [MD];
    logic [W-1:0]    dly_a_reg  [MD][3];
    logic [W-1:0]    dly_b_reg  [MD][3];
    logic [W-1:0]    dly_s_reg  [MD];

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_op_reg[0] <= in_op_reg;
            dly_a_reg[0]  <= in_a_reg;
            dly_b_reg[0]  <= in_b_reg;
            dly_s_reg[0]  <= in_s_reg;
            for (int k = 1; k < MD; k++) begin
                dly_op_reg[k] <= dly_op_reg[k-1];
                dly_a_reg[k]  <= dly_a_reg[k-1];
                dly_b_reg[k]  <= dly_b_reg[k-1];
                dly_s_reg[k]  <= dly_s_reg[k-1];
            end
        end
    end

    // decision stage: divisor, quotient signs, flags and status
    logic [OP_W-1:0] t_op;
    logic [W-1:0]    t_s;
    lane_flags_t     dec_flg_next;
    logic [ERR_W-1:0] dec_err_next;
    logic            dec_lim_next;
    logic            is_div;

    assign t_op   = dly_op_reg[MD-1];
    assign t_s    = dly_s_reg[MD-1];
    assign is_div = (t_op == OP_DIV);

    always_comb begin
        dec_flg_next.op     = t_op;
        dec_flg_next.s_zero = (t_s == '0);
        dec_flg_next.m_zero = (mag == '0);
        dec_flg_next.go     = t_s[W-1] | (mag > t_s);
        dec_err_next        = ERR_NONE;
        dec_lim_next        = 1'b0;
        if (is_div && dec_flg_next.s_zero) begin
            dec_err_next = ERR_DIV_ZERO;
        end else if ((t_op == OP_NORM && dec_flg_next.m_zero) ||
                     (t_op == OP_LIMIT && dec_flg_next.go && dec_flg_next.m_zero)) begin
            dec_err_next = ERR_ZERO_VEC;
        end
        if (t_op == OP_LIMIT && dec_flg_next.go && !dec_flg_next.m_zero) begin
            dec_lim_next = 1'b1;
        end
    end

    lane_flags_t      dec_flg_reg;
    logic [W-1:0]     dec_a_reg  [3];
    logic [W-1:0]     dec_b_reg  [3];
    logic [W-1:0]     dec_s_reg;
    logic [W-1:0]     dec_d_reg;
    logic [2:0]       dec_qn_reg;
    logic [ERR_W-1:0] dec_err_reg;
    logic             dec_lim_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dec_flg_reg <= dec_flg_next;
            dec_a_reg   <= dly_a_reg[MD-1];
            dec_b_reg   <= dly_b_reg[MD-1];
            dec_s_reg   <= t_s;
            dec_d_reg   <= is_div ? absw(t_s) : mag;
            for (int i = 0; i < 3; i++) begin
                dec_qn_reg[i] <= dly_a_reg[MD-1][i][W-1] ^ (is_div & t_s[W-1]);
            end
            dec_err_reg <= dec_err_next;
            dec_lim_reg <= dec_lim_next;
        end
    end

    // component lanes
    logic [W-1:0] lane_r [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vau_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .aclk  (aclk),
            .en    (en),
            .flags (dec_flg_reg),
            .a     (dec_a_reg[i]),
            .b     (dec_b_reg[i]),
            .s     (dec_s_reg),
            .dvs   (dec_d_reg),
            .qneg  (dec_qn_reg[i]),
            .r     (lane_r[i])
        );
    end

    // status delayed alongside the lanes
    logic [ERR_W-1:0] cerr_reg [LD];
    logic             clim_reg [LD];

    always_ff @(posedge aclk) begin
        if (en) begin
            cerr_reg[0] <= dec_err_reg;
            clim_reg[0] <= dec_lim_reg;
            for (int k = 1; k < LD; k++) begin
                cerr_reg[k] <= cerr_reg[k-1];
                clim_reg[k] <= clim_reg[k-1];
            end
        end
    end

    // merge lanes into one result word
    logic [MDW-1:0] tail_data;
    logic [ERR_W:0] tail_user;
    logic           tail_vld;
    logic           out_free;

    assign tail_data = MDW'({lane_r[2], lane_r[1], lane_r[0]});
    assign tail_user = {clim_reg[LD-1], cerr_reg[LD-1]};
    assign tail_vld  = vld_reg[VD-1];
    assign out_free  = ~m_tvalid | m_tready;

    // output register and skid register, control
    logic m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_vld_reg) begin
                m_tvalid_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= tail_vld;
            end
        end else if (tail_vld && en) begin
            skid_vld_reg <= 1'b1;
        end
    end

    // output register and skid register, payload
    logic [MDW-1:0] out_data_reg, skid_data_reg;
    logic [ERR_W:0] out_user_reg, skid_user_reg;

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_vld_reg) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end else begin
                out_data_reg <= tail_data;
                out_user_reg <= tail_user;
            end
        end else if (tail_vld && en) begin
            skid_data_reg <= tail_data;
            skid_user_reg <= tail_user;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[src/vau_checker.sv]
// Port-level checks for vector3_arith_unit_top, attached by bind.
// Uses vau_pkg.
module vau_checker
    import vau_pkg::*;
#(
    parameter int DATA_WIDTH = VAU_DATA_WIDTH
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic [ERR_W:0]                    m_tuser
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // status code is never the unused value
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[ERR_W-1:0] != 2'd3)
        else $error("undefined status code");

    // a rescaled vector carries no error
    a_lim_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[ERR_W] |-> m_tuser[ERR_W-1:0] == ERR_NONE)
        else $error("rescale flagged together with an error");

    // zero-vector error gives a zero result
    a_zero_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[ERR_W-1:0] == ERR_ZERO_VEC |-> m_tdata == '0)
        else $error("zero-vector result not cleared");

endmodule

bind vector3_arith_unit_top vau_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_vau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
